// File: rtl/bcm_pkg.sv
// shared constants, types and helper functions of the binary cross morphology block
package bcm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = COL_W + 1;
  localparam int ROW_W       = 16;
  localparam int CFG_WIDTH_W = 11;
  localparam int CMP_W       = (WID_W > CFG_WIDTH_W) ? WID_W : CFG_WIDTH_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DILATE_MODE  = 2'd2;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam logic [CFG_WIDTH_W-1:0] RESET_IMAGE_WIDTH  = 11'd1024;
  localparam logic [ROW_W-1:0]       RESET_IMAGE_HEIGHT = 16'd1024;
  localparam logic                   RESET_DILATE_MODE  = 1'b0;

  typedef struct packed {
    logic shift;
    logic shift_bit;
    logic emit;
    logic frame_end;
    logic left_ok;
    logic right_ok;
    logic up_ok;
    logic dilate;
  } ctrl_t;

  typedef struct packed {
    logic right;
    logic centre;
    logic left;
    logic up;
  } taps_t;

  function automatic logic [WID_W-1:0] eff_width(input logic [CFG_WIDTH_W-1:0] value);
    logic [CMP_W-1:0] v;
    logic [WID_W-1:0] r;
    v = CMP_W'(value);
    if (v == '0) begin
      r = WID_W'(1);
    end else if (v > CMP_W'(MAX_WIDTH)) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] value);
    logic [ROW_W-1:0] r;
    r = (value == '0) ? ROW_W'(1) : value;
    return r;
  endfunction

  function automatic logic [COL_W-1:0] head_of(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] d;
    d = WID_W'(MAX_WIDTH) - w;
    return d[COL_W-1:0];
  endfunction

endpackage

// File: rtl/bcm_ifs.sv
// valid/ready channel interfaces for pixels, results and configuration
interface bcm_in_if;
  import bcm_pkg::*;
  logic valid;
  logic ready;
  logic func;
  logic pixel_in;
  modport source(output valid, func, pixel_in, input ready);
  modport sink(input valid, func, pixel_in, output ready);
endinterface

interface bcm_out_if;
  import bcm_pkg::*;
  logic valid;
  logic ready;
  logic pixel_out;
  logic frame_end;
  modport source(output valid, pixel_out, frame_end, input ready);
  modport sink(input valid, pixel_out, frame_end, output ready);
endinterface

interface bcm_cfg_if;
  import bcm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;
  modport source(output valid, reg_index, reg_data, input ready);
  modport sink(input valid, reg_index, reg_data, output ready);
endinterface

// File: rtl/bcm_cell.sv
// one line buffer cell: loads a new pixel at the row head, else takes its neighbor
module bcm_cell (
  input  logic clk,
  input  logic shift,
  input  logic head,
  input  logic new_bit,
  input  logic prev_bit,
  output logic q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= head ? new_bit : prev_bit;
    end
  end

endmodule

// File: rtl/bcm_line.sv
// two rows of cells with a movable head giving delays of w-1, w, w+1 and 2w pixels
module bcm_line (
  input  logic                       clk,
  input  logic                       shift,
  input  logic                       shift_bit,
  input  logic [bcm_pkg::COL_W-1:0]  head,
  output bcm_pkg::taps_t             taps
);
  import bcm_pkg::*;

  logic [MAX_WIDTH-1:0] head_hit;
  logic [MAX_WIDTH-1:0] near_q;
  logic [MAX_WIDTH-1:0] far_q;
  logic [MAX_WIDTH-1:0] near_prev;
  logic [MAX_WIDTH-1:0] far_prev;
  logic                 near_tail;

  assign near_prev = {near_q[MAX_WIDTH-2:0], 1'b0};
  assign far_prev  = {far_q[MAX_WIDTH-2:0], 1'b0};

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cells
    assign head_hit[k] = (head == COL_W'(k));

    bcm_cell u_near (
      .clk      (clk),
      .shift    (shift),
      .head     (head_hit[k]),
      .new_bit  (shift_bit),
      .prev_bit (near_prev[k]),
      .q        (near_q[k])
    );

    bcm_cell u_far (
      .clk      (clk),
      .shift    (shift),
      .head     (head_hit[k]),
      .new_bit  (near_q[MAX_WIDTH-1]),
      .prev_bit (far_prev[k]),
      .q        (far_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      near_tail <= near_q[MAX_WIDTH-1];
    end
  end

  assign taps.right  = near_q[MAX_WIDTH-2];
  assign taps.centre = near_q[MAX_WIDTH-1];
  assign taps.left   = near_tail;
  assign taps.up     = far_q[MAX_WIDTH-1];

endmodule

// File: rtl/bcm_ctrl.sv
// configuration registers and input/output position counters
module bcm_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_accept,
  input  logic                            func,
  input  logic                            pixel_in,
  input  logic                            cfg_write,
  input  logic [bcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bcm_pkg::ctrl_t                  ctl,
  output logic [bcm_pkg::COL_W-1:0]       head
);
  import bcm_pkg::*;

  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] height;
  logic [ROW_W-1:0] last_row;
  logic             dilate;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  logic [WID_W-1:0] new_width;
  logic [ROW_W-1:0] new_height;
  logic             cfg_restart;
  logic             is_pixel;
  logic             in_done;
  logic             pix_take;
  logic             flush_take;
  logic             col_end;
  logic             row_end;

  assign new_width   = eff_width(cfg_data[CFG_WIDTH_W-1:0]);
  assign new_height  = eff_height(cfg_data[ROW_W-1:0]);
  assign cfg_restart = cfg_write &&
                       (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_DILATE_MODE});

  assign is_pixel   = (func == FUNC_PIXEL);
  assign in_done    = (in_row >= height);
  assign pix_take   = is_pixel && !in_done;
  assign flush_take = (func == FUNC_FLUSH) && in_done;
  assign col_end    = (out_col == last_col);
  assign row_end    = (out_row == last_row);

  assign ctl.shift     = in_accept && (pix_take || flush_take);
  assign ctl.shift_bit = is_pixel && pixel_in;
  assign ctl.emit      = in_accept && ((pix_take && (in_row != '0)) || flush_take);
  assign ctl.frame_end = in_accept && flush_take && col_end && row_end;
  assign ctl.left_ok   = (out_col != '0);
  assign ctl.right_ok  = !col_end;
  assign ctl.up_ok     = (out_row != '0);
  assign ctl.dilate    = dilate;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= COL_W'(eff_width(RESET_IMAGE_WIDTH) - WID_W'(1));
      head     <= head_of(eff_width(RESET_IMAGE_WIDTH));
      height   <= eff_height(RESET_IMAGE_HEIGHT);
      last_row <= eff_height(RESET_IMAGE_HEIGHT) - ROW_W'(1);
      dilate   <= RESET_DILATE_MODE;
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          last_col <= COL_W'(new_width - WID_W'(1));
          head     <= head_of(new_width);
        end
        REG_IMAGE_HEIGHT: begin
          height   <= new_height;
          last_row <= new_height - ROW_W'(1);
        end
        REG_DILATE_MODE: begin
          dilate <= cfg_data[0];
        end
        default: begin
        end
      endcase
      if (cfg_restart) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end
    end else begin
      if (in_accept && pix_take) begin
        if (in_col == last_col) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (ctl.emit) begin
        if (col_end) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
      if (ctl.frame_end) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_in_row_bound: assert property (@(posedge clk) disable iff (rst) in_row <= height)
    else $error("input row beyond frame height");

  a_out_lags_in: assert property (@(posedge clk) disable iff (rst)
    (in_row != '0 && in_row < height) |->
      (out_row == in_row - ROW_W'(1) && out_col == in_col))
    else $error("output position not one row behind input");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    ctl.frame_end |=>
      (in_row == '0 && in_col == '0 && out_row == '0 && out_col == '0))
    else $error("counters not restarted after frame end");
`endif

endmodule

// File: rtl/binary_cross_morphology.sv
// binary erosion/dilation with a 3x3 cross over a raster-order pixel stream
// a result is registered into the output register, or into the skid entry while the output is stalled
// throughput: one item per clock while the skid entry is empty, each pixel or pending flush shifts the line cells once
// a two-entry output stage keeps input flowing while a result waits in the output register
// reset (rst, synchronous): registers to defaults, counters cleared, line cells not cleared
module binary_cross_morphology (
  input  logic       clk,
  input  logic       rst,
  bcm_in_if.sink     pixels,
  bcm_out_if.source  results,
  bcm_cfg_if.sink    cfg
);
  import bcm_pkg::*;

  ctrl_t            ctl;
  taps_t            taps;
  logic [COL_W-1:0] head;
  logic             in_accept;
  logic             cfg_write;
  logic             push;
  logic             pop;
  logic             new_pixel;
  logic             up_m;
  logic             left_m;
  logic             right_m;

  logic out_valid;
  logic out_pixel;
  logic out_end;
  logic skid_valid;
  logic skid_pixel;
  logic skid_end;

  assign cfg.ready    = 1'b1;
  assign cfg_write    = cfg.valid && cfg.ready;
  assign pixels.ready = !skid_valid;
  assign in_accept    = pixels.valid && pixels.ready;

  bcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .func      (pixels.func),
    .pixel_in  (pixels.pixel_in),
    .cfg_write (cfg_write),
    .cfg_index (cfg.reg_index),
    .cfg_data  (cfg.reg_data),
    .ctl       (ctl),
    .head      (head)
  );

  bcm_line u_line (
    .clk       (clk),
    .shift     (ctl.shift),
    .shift_bit (ctl.shift_bit),
    .head      (head),
    .taps      (taps)
  );

  // neighbors outside the image count as 0
  assign up_m    = taps.up && ctl.up_ok;
  assign left_m  = taps.left && ctl.left_ok;
  assign right_m = taps.right && ctl.right_ok;
  assign new_pixel = ctl.dilate ?
    (taps.centre | up_m | left_m | right_m | ctl.shift_bit) :
    (taps.centre & up_m & left_m & right_m & ctl.shift_bit);

  assign push = ctl.emit;
  assign pop  = out_valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_pixel <= skid_pixel;
        out_end   <= skid_end;
      end else if (push) begin
        out_pixel <= new_pixel;
        out_end   <= ctl.frame_end;
      end
    end else if (push) begin
      skid_pixel <= new_pixel;
      skid_end   <= ctl.frame_end;
    end
  end

  assign results.valid     = out_valid;
  assign results.pixel_out = out_pixel;
  assign results.frame_end = out_end;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !pop) |=> skid_valid)
    else $error("result lost while output stalled");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (pop && !skid_valid && !push) |=> !out_valid)
    else $error("transaction repeated after drain");
`endif

endmodule

// File: verif/testbench.sv
// testbench for binary_cross_morphology: directed table, then random frames checked against a predictor
module testbench;
  import bcm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int DIR_ROWS      = 28;
  localparam int WIDE_TAIL     = 64;

  typedef struct packed {
    logic pixel_out;
    logic frame_end;
  } pix_result_t;

  typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  func;
    logic                  pix;
    logic                  typed;
    logic                  t_has;
    logic                  t_out;
    logic                  t_fe;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  bcm_in_if  pixels();
  bcm_out_if results();
  bcm_cfg_if cfg();

  binary_cross_morphology dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels),
    .results (results),
    .cfg     (cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic                   line_bits [2*MAX_WIDTH];
  logic [CFG_WIDTH_W-1:0] cfg_width;
  logic [ROW_W-1:0]       cfg_height;
  logic                   cfg_dilate;
  logic [WID_W-1:0]       in_col;
  logic [WID_W-1:0]       out_col;
  logic [ROW_W-1:0]       in_row;
  logic [ROW_W-1:0]       out_row;

  pix_result_t pending_pixels [$];
  pix_result_t want_pixel;
  int unsigned mismatches = 0;
  int unsigned counted_items = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          counting = 1'b0;
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  dir_row_t    script [DIR_ROWS];

  function automatic logic [WID_W-1:0] active_width();
    if (cfg_width == '0) return WID_W'(1);
    if (cfg_width > CFG_WIDTH_W'(MAX_WIDTH)) return WID_W'(MAX_WIDTH);
    return WID_W'(cfg_width);
  endfunction

  function automatic logic [ROW_W-1:0] active_height();
    return (cfg_height == '0) ? ROW_W'(1) : cfg_height;
  endfunction

  function automatic int unsigned line_slot(input logic parity, input logic [WID_W-1:0] col);
    return {parity, col[COL_W-1:0]};
  endfunction

  function automatic logic cross_value(input logic down, input logic [WID_W-1:0] w);
    logic centre, up, left, right;
    centre = line_bits[line_slot(out_row[0], out_col)];
    up     = (out_row != '0) ? line_bits[line_slot(~out_row[0], out_col)] : 1'b0;
    left   = (out_col != '0) ? line_bits[line_slot(out_row[0], out_col - 1'b1)] : 1'b0;
    right  = (WID_W'(out_col + 1'b1) < w) ?
             line_bits[line_slot(out_row[0], out_col + 1'b1)] : 1'b0;
    return cfg_dilate ? (centre | up | left | right | down)
                      : (centre & up & left & right & down);
  endfunction

  task automatic restart_frame();
    in_col  = '0;
    in_row  = '0;
    out_col = '0;
    out_row = '0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        cfg_width = data[CFG_WIDTH_W-1:0];
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        cfg_height = data[ROW_W-1:0];
        restart_frame();
      end
      REG_DILATE_MODE: begin
        cfg_dilate = data[0];
        restart_frame();
      end
      default: ;
    endcase
  endtask

  task automatic cross_step(input logic f, input logic p, output logic has,
                            output pix_result_t res, output logic taken);
    logic [WID_W-1:0] w;
    logic [ROW_W-1:0] h;
    w = active_width();
    h = active_height();
    has = 1'b0;
    taken = 1'b0;
    res = '0;
    if (f == FUNC_PIXEL) begin
      if (in_row < h) begin
        taken = 1'b1;
        if (in_row != '0) begin
          res.pixel_out = cross_value(p, w);
          has = 1'b1;
          out_col = out_col + 1'b1;
          if (out_col >= w) begin
            out_col = '0;
            out_row = out_row + 1'b1;
          end
        end
        line_bits[line_slot(in_row[0], in_col)] = p;
        in_col = in_col + 1'b1;
        if (in_col >= w) begin
          in_col = '0;
          in_row = in_row + 1'b1;
        end
      end
    end else if (in_row >= h && out_row < h) begin
      taken = 1'b1;
      has = 1'b1;
      res.pixel_out = cross_value(1'b0, w);
      out_col = out_col + 1'b1;
      if (out_col >= w) begin
        out_col = '0;
        out_row = out_row + 1'b1;
        if (out_row >= h) begin
          res.frame_end = 1'b1;
          restart_frame();
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic send_item(input logic f, input logic p, input logic typed,
                           input logic t_has, input logic t_out, input logic t_fe);
    logic        has, taken;
    pix_result_t res;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 25) begin
      pixels.valid <= 1'b0;
      @(negedge clk);
    end
    pixels.valid    <= 1'b1;
    pixels.func     <= f;
    pixels.pixel_in <= p;
    @(posedge clk);
    while (!pixels.ready) @(posedge clk);
    cross_step(f, p, has, res, taken);
    if (typed) begin
      has = t_has;
      res.pixel_out = t_out;
      res.frame_end = t_fe;
    end
    if (has) pending_pixels.push_back(res);
    if (taken && counting) counted_items++;
  endtask

  task automatic send_plain(input logic f, input logic p);
    send_item(f, p, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    pixels.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.reg_data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic stream_frame(input bit noisy, input bit hold_mid);
    int unsigned total, dens, k;
    total = int'(active_width()) * int'(active_height());
    dens = $urandom_range(0, 100);
    for (k = 0; k < total; k++) begin
      if (noisy && $urandom_range(0, 99) < 8) send_plain(FUNC_FLUSH, 1'($urandom));
      send_plain(FUNC_PIXEL, $urandom_range(0, 99) < dens);
    end
    if (noisy) repeat ($urandom_range(1, 3)) send_plain(FUNC_PIXEL, 1'($urandom));
    if (hold_mid) hold_request = 1'b1;
    for (k = 0; k < active_width(); k++) send_plain(FUNC_FLUSH, 1'($urandom));
    if (noisy) send_plain(FUNC_FLUSH, 1'($urandom));
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      results.ready <= 1'b0;
    end else begin
      results.ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected pixel_out=%0b frame_end=%0b",
                                results.pixel_out, results.frame_end));
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (results.pixel_out !== want_pixel.pixel_out)
          flag_mismatch($sformatf("pixel_out got %0b want %0b",
                                  results.pixel_out, want_pixel.pixel_out));
        if (results.frame_end !== want_pixel.frame_end)
          flag_mismatch($sformatf("frame_end got %0b want %0b",
                                  results.frame_end, want_pixel.frame_end));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixels.valid && pixels.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] wd, hd, dd;
    int unsigned frame, sel, start, k, n, wv;
    rst              = 1'b1;
    pixels.valid     = 1'b0;
    pixels.func      = FUNC_PIXEL;
    pixels.pixel_in  = 1'b0;
    cfg.valid        = 1'b0;
    cfg.reg_index    = REG_IMAGE_WIDTH;
    cfg.reg_data     = '0;
    cfg_width        = RESET_IMAGE_WIDTH;
    cfg_height       = RESET_IMAGE_HEIGHT;
    cfg_dilate       = RESET_DILATE_MODE;
    foreach (line_bits[i]) line_bits[i] = 1'b0;
    restart_frame();

    script = '{
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_WIDTH,  16'hF801, FUNC_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 16'h0000, FUNC_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{STEP_WRITE, REG_DILATE_MODE,  16'hFFFF, FUNC_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
      '{STEP_WRITE, REG_IMAGE_WIDTH,  16'h0003, FUNC_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 16'h0002, FUNC_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_WRITE, REG_DILATE_MODE,  16'hFFFE, FUNC_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_WRITE, REG_UNUSED,       16'hFFFF, FUNC_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_PIXEL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{STEP_ITEM,  REG_IMAGE_WIDTH,  16'h0000, FUNC_FLUSH, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE) begin
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_item(script[i].func, script[i].pix, script[i].typed,
                  script[i].t_has, script[i].t_out, script[i].t_fe);
      end
    end

    counting = 1'b1;
    frame = 0;
    while (counted_items < RANDOM_ITEMS) begin
      frame++;
      steady = (frame >= 8 && frame < 16);
      if (frame == 6) begin
        // widest row, receiver holds off partway through the second row
        write_reg(REG_IMAGE_WIDTH, 16'h07FF);
        write_reg(REG_IMAGE_HEIGHT, 16'h0002);
        write_reg(REG_DILATE_MODE, 16'($urandom));
        repeat (int'(active_width())) send_plain(FUNC_PIXEL, 1'($urandom));
        hold_request = 1'b1;
        repeat (WIDE_TAIL) send_plain(FUNC_PIXEL, 1'($urandom));
        write_reg(REG_IMAGE_WIDTH, 16'h0004);
      end else if (frame == 12) begin
        // tallest frame, abandoned after a few rows
        write_reg(REG_IMAGE_WIDTH, 16'h0002);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        repeat (12) send_plain(FUNC_PIXEL, 1'($urandom));
        repeat (3) send_plain(FUNC_FLUSH, 1'($urandom));
        write_reg(REG_IMAGE_HEIGHT, 16'h0003);
      end else begin
        sel = $urandom_range(0, 99);
        wv = (sel < 5) ? 0 : (sel < 15) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        wd = {5'($urandom_range(0, 31)), 11'(wv)};
        sel = $urandom_range(0, 99);
        hd = (sel < 5) ? 16'h0000 : 16'($urandom_range(1, 6));
        dd = 16'($urandom);
        start = $urandom_range(0, 2);
        for (k = 0; k < 3; k++) begin
          if ($urandom_range(0, 99) < 80) begin
            case (CFG_IDX_W'((start + k) % 3))
              REG_IMAGE_WIDTH:  write_reg(REG_IMAGE_WIDTH, wd);
              REG_IMAGE_HEIGHT: write_reg(REG_IMAGE_HEIGHT, hd);
              default:          write_reg(REG_DILATE_MODE, dd);
            endcase
          end
        end
        if ($urandom_range(0, 99) < 10) write_reg(REG_UNUSED, 16'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          stream_frame(1'b0, 1'b0);
        end else if (sel < 90) begin
          stream_frame(1'b1, 1'b0);
        end else begin
          n = $urandom_range(1, 2 * int'(active_width()) * int'(active_height()) +
                                int'(active_width()));
          repeat (n) send_plain($urandom_range(0, 99) < 30, 1'($urandom));
        end
      end
    end
    steady = 1'b0;

    @(negedge clk);
    pixels.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: binary_cross_morphology.f
rtl/bcm_pkg.sv
rtl/bcm_ifs.sv
rtl/bcm_cell.sv
rtl/bcm_line.sv
rtl/bcm_ctrl.sv
rtl/binary_cross_morphology.sv
verif/testbench.sv
